[sv/sma_pkg.sv]
// Shared types, constants and index helpers for the small matrix adjugate/inverse block.
`default_nettype none
package sma_pkg;

	// Field widths
	localparam int ELEM_W = 16;
	localparam int ADJ_W  = 33;
	localparam int INV_W  = 49;
	localparam int DET_W  = 52;
	localparam int PROD_W = ELEM_W + ADJ_W;
	localparam int FRAC_W = 16;

	// Store layout: fixed stride of three for the adjugate store
	localparam int STORE_DEPTH = 9;
	localparam int IDX_W       = 4;
	localparam logic [1:0] ADJ_STRIDE = 2'd3;
	localparam int MAX_DIM_DEF = 3;

	// Sequencer phases
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_MINOR,
		ST_DET,
		ST_DIV
	} state_t;

	// Accumulator operations of the shared multiply unit
	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_CLR,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		logic    mul;
		acc_op_t op;
	} mac_ctl_t;

	// Source of the wide multiplier operand
	typedef enum logic [1:0] {
		OPB_HOLD,
		OPB_ELEM,
		OPB_ONE,
		OPB_ADJ
	} opb_sel_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Lower of the two indices other than x (0..2)
	function automatic logic [1:0] other_lo(input logic [1:0] x);
		return (x == 2'd0) ? 2'd1 : 2'd0;
	endfunction

	// Upper of the two indices other than x (0..2)
	function automatic logic [1:0] other_hi(input logic [1:0] x);
		return (x == 2'd2) ? 2'd1 : 2'd2;
	endfunction

	// Linear index r*n+c
	function automatic logic [IDX_W-1:0] lin_idx(input logic [1:0] r, input logic [1:0] c,
			input logic [1:0] n);
		logic [IDX_W-1:0] p;
		p = IDX_W'(r) * IDX_W'(n);
		return p + IDX_W'(c);
	endfunction

endpackage
`default_nettype wire

[sv/sma_mac.sv]
// Shared multiply unit with registered product and accumulator.
`default_nettype none
module sma_mac
	import sma_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mac_ctl_t                 ctl,
	input  wire logic signed [ELEM_W-1:0] op_a,
	input  wire logic signed [ADJ_W-1:0]  op_b,
	output logic signed [DET_W-1:0]       acc
);

	logic signed [PROD_W-1:0] prod_q;
	logic signed [DET_W-1:0]  acc_q;
	logic signed [DET_W-1:0]  prod_ext;

	assign prod_ext = DET_W'(prod_q);
	assign acc      = acc_q;

	// product register
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= PROD_W'(op_a * op_b);
		end
	end

	// accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			case (ctl.op)
				ACC_CLR:  acc_q <= '0;
				ACC_LOAD: acc_q <= prod_ext;
				ACC_ADD:  acc_q <= acc_q + prod_ext;
				ACC_SUB:  acc_q <= acc_q - prod_ext;
				default:  acc_q <= acc_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[sv/sma_div.sv]
// Iterative restoring signed divider, one quotient bit per cycle.
`default_nettype none
module sma_div
	import sma_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [INV_W-1:0] numer,
	input  wire logic signed [DET_W-1:0] denom,
	output div_stat_t                    stat,
	output logic signed [INV_W-1:0]      quot
);

	localparam int CNT_W = $clog2(INV_W);
	localparam logic [CNT_W-1:0] LastCnt = CNT_W'(INV_W - 1);

	logic [DET_W:0]   rem_q;
	logic [INV_W-1:0] num_q;
	logic [INV_W-1:0] quo_q;
	logic [DET_W-1:0] den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [INV_W-1:0] nmag;
	logic [DET_W-1:0] dmag;
	logic [DET_W:0]   trial;
	logic             ge;

	assign nmag  = numer[INV_W-1] ? INV_W'(-numer) : INV_W'(numer);
	assign dmag  = denom[DET_W-1] ? DET_W'(-denom) : DET_W'(denom);
	assign trial = {rem_q[DET_W-1:0], num_q[INV_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = neg_q ? INV_W'(-quo_q) : INV_W'(quo_q);

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= nmag;
			den_q <= dmag;
			quo_q <= '0;
			neg_q <= numer[INV_W-1] ^ denom[DET_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			num_q <= {num_q[INV_W-2:0], 1'b0};
			quo_q <= {quo_q[INV_W-2:0], ge};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LastCnt) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[sv/small_matrix_adjugate_inverse.sv]
// Load: one word per cycle, n*n words. Then a signed minor per adjugate entry (n>1) and
// a determinant term per column of row 0 on the one shared multiplier, then a division per
// inverse entry on the 49-step shared divider (none when singular).
// Input is stalled while a matrix is being worked on.
// Reset (arst_n low) sets matrix_size to 3, empties the load and clears all control
// state; the element store is not cleared.
`default_nettype none
module small_matrix_adjugate_inverse
	import sma_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// config port
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [1:0]               paddr,
	input  wire logic [31:0]              pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// input words
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [ELEM_W-1:0] element,
	// result words
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [1:0]                    out_row,
	output logic [1:0]                    out_col,
	output logic signed [ADJ_W-1:0]       adj_entry,
	output logic signed [INV_W-1:0]       inv_entry,
	output logic signed [DET_W-1:0]       determinant,
	output logic                          singular,
	output logic                          last
);

	localparam logic [1:0] MaxN = 2'(MAX_DIM);

	// config
	logic [1:0] size_q;
	logic       cfg_we;
	logic [1:0] n_eff;
	logic [IDX_W-1:0] total;

	assign pready = 1'b1;
	assign prdata = {30'd0, size_q};
	assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
	assign n_eff  = (size_q == 2'd0) ? 2'd1 : ((size_q > MaxN) ? MaxN : size_q);
	assign total  = lin_idx(n_eff, 2'd0, n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 2'd3;
		end else if (cfg_we) begin
			size_q <= pwdata[1:0];
		end
	end

	// sequencer registers
	state_t state_q, state_d;
	logic [2:0] step_q, step_d;
	logic [1:0] row_q, row_d, col_q, col_d;
	logic [IDX_W-1:0] cnt_q;

	// memories
	logic signed [ELEM_W-1:0] elem_mem [STORE_DEPTH];
	logic signed [ADJ_W-1:0]  adj_mem  [STORE_DEPTH];
	logic signed [ELEM_W-1:0] e_rd_q;
	logic signed [ADJ_W-1:0]  a_rd_q;
	logic [IDX_W-1:0] e_raddr, a_raddr, a_waddr;
	logic             adj_we;
	logic signed [ADJ_W-1:0]  adj_wdata;

	// operands and shared units
	logic signed [ELEM_W-1:0] op_a_q;
	logic signed [ADJ_W-1:0]  op_b_q;
	logic signed [ADJ_W-1:0]  adj_q;
	logic       opa_ld;
	opb_sel_t   opb_sel;
	mac_ctl_t   mac_ctl;
	logic signed [DET_W-1:0]  acc;
	logic       div_start;
	div_stat_t  div_stat;
	logic signed [INV_W-1:0]  quot;
	logic       sing;
	logic       out_load;
	logic       out_free;
	logic       in_take;
	logic       n_two;
	logic       last_rc;
	logic [1:0] r0, r1, c0, c1;

	assign sing     = (acc == '0);
	assign n_two    = (n_eff == 2'd2);
	assign in_stall = (state_q != ST_LOAD);
	assign in_take  = in_valid && (state_q == ST_LOAD);
	assign out_free = !out_valid || !out_stall;
	assign last_rc  = (row_q == n_eff - 2'd1) && (col_q == n_eff - 2'd1);
	// minor of (col,row): rows other than col, columns other than row
	assign r0 = other_lo(col_q);
	assign r1 = other_hi(col_q);
	assign c0 = other_lo(row_q);
	assign c1 = other_hi(row_q);
	assign a_waddr = lin_idx(row_q, col_q, ADJ_STRIDE);

	sma_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a_q),
		.op_b   (op_b_q),
		.acc    (acc)
	);

	sma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  ({a_rd_q[ADJ_W-1:0], FRAC_W'(0)}),
		.denom  (acc),
		.stat   (div_stat),
		.quot   (quot)
	);

	// next state and control
	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		row_d     = row_q;
		col_d     = col_q;
		e_raddr   = '0;
		a_raddr   = '0;
		opa_ld    = 1'b0;
		opb_sel   = OPB_HOLD;
		mac_ctl   = '{mul: 1'b0, op: ACC_HOLD};
		adj_we    = 1'b0;
		adj_wdata = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (in_take && (cnt_q == total - 1'b1)) begin
					state_d = ST_MINOR;
					step_d  = '0;
					row_d   = '0;
					col_d   = '0;
				end
			end
			ST_MINOR: begin
				if (n_eff == 2'd1) begin
					adj_we    = 1'b1;
					adj_wdata = ADJ_W'(1);
					state_d   = ST_DET;
				end else begin
					step_d = step_q + 1'b1;
					case (step_q)
						3'd0: e_raddr = lin_idx(r0, c0, n_eff);
						3'd1: begin
							opa_ld  = 1'b1;
							e_raddr = lin_idx(r1, c1, n_eff);
						end
						3'd2: begin
							opb_sel = n_two ? OPB_ONE : OPB_ELEM;
							e_raddr = lin_idx(r0, c1, n_eff);
						end
						3'd3: begin
							mac_ctl.mul = 1'b1;
							opa_ld      = 1'b1;
							e_raddr     = lin_idx(r1, c0, n_eff);
						end
						3'd4: begin
							mac_ctl.op = ACC_LOAD;
							opb_sel    = n_two ? OPB_HOLD : OPB_ELEM;
						end
						3'd5: mac_ctl.mul = 1'b1;
						3'd6: mac_ctl.op = n_two ? ACC_HOLD : ACC_SUB;
						default: begin
							adj_we    = 1'b1;
							adj_wdata = (row_q[0] ^ col_q[0]) ? ADJ_W'(-acc) : ADJ_W'(acc);
							step_d    = '0;
							if (col_q == n_eff - 2'd1) begin
								col_d = '0;
								if (row_q == n_eff - 2'd1) begin
									row_d   = '0;
									state_d = ST_DET;
								end else begin
									row_d = row_q + 1'b1;
								end
							end else begin
								col_d = col_q + 1'b1;
							end
						end
					endcase
				end
			end
			ST_DET: begin
				// det = sum over j of a[0][j] * adj[j][0]
				step_d = step_q + 1'b1;
				case (step_q)
					3'd0: begin
						e_raddr = IDX_W'(col_q);
						a_raddr = lin_idx(col_q, 2'd0, ADJ_STRIDE);
						if (col_q == 2'd0) begin
							mac_ctl.op = ACC_CLR;
						end
					end
					3'd1: begin
						opa_ld  = 1'b1;
						opb_sel = OPB_ADJ;
					end
					3'd2: mac_ctl.mul = 1'b1;
					default: begin
						mac_ctl.op = ACC_ADD;
						step_d     = '0;
						if (col_q == n_eff - 2'd1) begin
							col_d   = '0;
							row_d   = '0;
							state_d = ST_DIV;
						end else begin
							col_d = col_q + 1'b1;
						end
					end
				endcase
			end
			ST_DIV: begin
				case (step_q)
					3'd0: begin
						a_raddr = a_waddr;
						step_d  = 3'd1;
					end
					3'd1: begin
						div_start = !sing;
						step_d    = 3'd2;
					end
					default: begin
						if ((sing || div_stat.done) && !div_stat.busy && out_free) begin
							out_load = 1'b1;
							step_d   = '0;
							if (last_rc) begin
								state_d = ST_LOAD;
								row_d   = '0;
								col_d   = '0;
							end else if (col_q == n_eff - 2'd1) begin
								col_d = '0;
								row_d = row_q + 1'b1;
							end else begin
								col_d = col_q + 1'b1;
							end
						end
					end
				endcase
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q  <= '0;
			row_q   <= '0;
			col_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			row_q   <= row_d;
			col_q   <= col_d;
			if (cfg_we) begin
				cnt_q <= '0;
			end else if (in_take) begin
				cnt_q <= (cnt_q == total - 1'b1) ? '0 : cnt_q + 1'b1;
			end
		end
	end

	// element store
	always_ff @(posedge clk) begin
		if (in_take) begin
			elem_mem[cnt_q] <= element;
		end
		e_rd_q <= elem_mem[e_raddr];
	end

	// adjugate store
	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[a_waddr] <= adj_wdata;
		end
		a_rd_q <= adj_mem[a_raddr];
	end

	// operand registers
	always_ff @(posedge clk) begin
		if (opa_ld) begin
			op_a_q <= e_rd_q;
		end
		case (opb_sel)
			OPB_ELEM: op_b_q <= ADJ_W'(e_rd_q);
			OPB_ONE:  op_b_q <= ADJ_W'(1);
			OPB_ADJ:  op_b_q <= a_rd_q;
			default:  op_b_q <= op_b_q;
		endcase
		if (state_q == ST_DIV && step_q == 3'd1) begin
			adj_q <= a_rd_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row     <= row_q;
			out_col     <= col_q;
			adj_entry   <= adj_q;
			inv_entry   <= sing ? '0 : quot;
			determinant <= acc;
			singular    <= sing;
			last        <= last_rc;
		end
	end

endmodule
`default_nettype wire
